[hdl/gaussian_row_blur_assert.svh]
// Assertion macros shared by the blur RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef GAUSSIAN_ROW_BLUR_ASSERT_SVH
`define GAUSSIAN_ROW_BLUR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define GRB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/grb_pkg.sv]
package grb_pkg;

	// Pixel layout: four byte channels, red in the lowest byte
	localparam int NUM_CH      = 4;
	localparam int PIX_W       = 8;
	localparam int WEIGHT_W    = 16;
	localparam int NUM_WEIGHTS = 5;
	localparam int WIDX_W      = $clog2(NUM_WEIGHTS);
	localparam int PROD_W      = PIX_W + WEIGHT_W;

	// Configuration port
	localparam int ROW_WIDTH_W = 13;
	localparam int RADIUS_W    = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 3;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_RADIUS = 4;
	localparam int DEF_MAX_WIDTH  = 4096;

	// Register reset values
	localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH = ROW_WIDTH_W'(64);
	localparam logic [RADIUS_W-1:0]    RST_RADIUS    = RADIUS_W'(2);
	localparam logic [WEIGHT_W-1:0]    RST_WEIGHT_0  = WEIGHT_W'(32768);
	localparam logic [WEIGHT_W-1:0]    RST_WEIGHT_1  = WEIGHT_W'(19875);
	localparam logic [WEIGHT_W-1:0]    RST_WEIGHT_2  = WEIGHT_W'(4435);
	localparam logic [WEIGHT_W-1:0]    RST_WEIGHT_3  = WEIGHT_W'(364);
	localparam logic [WEIGHT_W-1:0]    RST_WEIGHT_4  = WEIGHT_W'(11);

	typedef logic [NUM_CH-1:0][PIX_W-1:0]         pixel_t;
	typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_tab_t;
	typedef logic [NUM_CH-1:0][PROD_W-1:0]        prod_vec_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH = 3'd0,
		REG_RADIUS    = 3'd1,
		REG_WEIGHT_0  = 3'd2,
		REG_WEIGHT_1  = 3'd3,
		REG_WEIGHT_2  = 3'd4,
		REG_WEIGHT_3  = 3'd5,
		REG_WEIGHT_4  = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_ADD,
		ST_DIV,
		ST_OUT
	} blur_state_t;

endpackage

[hdl/grb_cell.sv]
// One window cell: holds one pixel of the current row, passes it on when a
// new pixel arrives, and forms its weighted contribution for the column in work.
module grb_cell #(
	parameter int SLOT   = 0,
	parameter int SLOT_W = 4,
	parameter int KW     = 3
) (
	input  logic                    clk,
	input  logic                    shift,
	input  grb_pkg::pixel_t         pix_in,
	output grb_pkg::pixel_t         pix_out,
	input  logic                    calc,
	input  logic [KW-1:0]           lag,
	input  logic [SLOT_W-1:0]       newest,
	input  logic [KW-1:0]           rad,
	input  grb_pkg::weight_tab_t    weights,
	output grb_pkg::prod_vec_t      prod,
	output logic [grb_pkg::WEIGHT_W-1:0] wt
);
	import grb_pkg::*;

	localparam logic [SLOT_W-1:0] S = SLOT_W'(SLOT);

	pixel_t              pix_q;
	prod_vec_t           prod_s1;
	logic [WEIGHT_W-1:0] wt_s1;
	logic [SLOT_W-1:0]   lag_w;
	logic [SLOT_W-1:0]   tap_off;
	logic [WIDX_W-1:0]   widx;
	logic                used;
	logic [WEIGHT_W-1:0] w;

	// Window shift
	always_ff @(posedge clk) begin
		if (shift) begin
			pix_q <= pix_in;
		end
	end

	// Distance from the output column, and the weight that applies
	always_comb begin
		lag_w   = SLOT_W'(lag);
		tap_off = (lag_w >= S) ? (lag_w - S) : (S - lag_w);
		widx    = WIDX_W'(tap_off);
		used    = (S <= newest) && (tap_off <= SLOT_W'(rad)) &&
		          (int'(tap_off) < NUM_WEIGHTS);
		w       = used ? weights[widx] : '0;
	end

	// Weighted channels, registered
	always_ff @(posedge clk) begin
		if (calc) begin
			for (int c = 0; c < NUM_CH; c++) begin
				prod_s1[c] <= PROD_W'(pix_q[c]) * PROD_W'(w);
			end
			wt_s1 <= w;
		end
	end

	assign pix_out = pix_q;
	assign prod    = prod_s1;
	assign wt      = wt_s1;

endmodule

[hdl/grb_div.sv]
// Restoring divider, one quotient bit per cycle for all channels at once.
// The quotient is a weighted mean of bytes, so it always fits in a byte.
module grb_div #(
	parameter int SUM_W = 28,
	parameter int WS_W  = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [grb_pkg::NUM_CH-1:0][SUM_W-1:0]  dividend,
	input  logic [WS_W-1:0]                        divisor,
	output logic                                   done,
	output grb_pkg::pixel_t                        quotient
);
	import grb_pkg::*;

	localparam int CNT_W = $clog2(PIX_W);
	localparam int DSH_W = WS_W + PIX_W - 1;
	localparam int CW    = (SUM_W > DSH_W) ? SUM_W : DSH_W;

	logic                           busy_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [NUM_CH-1:0][SUM_W-1:0]   rem_q;
	logic [NUM_CH-1:0][SUM_W-1:0]   rem_nx;
	logic [DSH_W-1:0]               dsh_q;
	logic                           zero_q;
	pixel_t                         q_q;
	logic [NUM_CH-1:0]              ge;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PIX_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Trial subtract per channel
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			ge[c]     = CW'(rem_q[c]) >= CW'(dsh_q);
			rem_nx[c] = ge[c] ? SUM_W'(CW'(rem_q[c]) - CW'(dsh_q)) : rem_q[c];
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= DSH_W'(divisor) << (PIX_W - 1);
			zero_q <= (divisor == '0);
			q_q    <= '0;
		end else if (busy_q) begin
			for (int c = 0; c < NUM_CH; c++) begin
				rem_q[c] <= rem_nx[c];
				q_q[c]   <= {q_q[c][PIX_W-2:0], ge[c]};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : q_q;

endmodule

[hdl/gaussian_row_blur.sv]
// Horizontal Gaussian blur over RGBA pixels in raster order. A pixel is taken
// when the block is idle; it then yields zero to MAX_RADIUS+1 blurred pixels
// (one once the row is radius pixels in, and all pending columns on the last
// pixel of a row, the final one with tlast set). Each blurred pixel is formed
// in steps: the 2*MAX_RADIUS+1 window cells are weighted, two half sums are
// registered and added, the shared 8-step divider renormalises by the weights
// in use, and the result goes to the output register once that is free. The
// output register lets the next pixel in while a result still waits.
// Configuration is to be written by the user only while no row work is in
// flight; the block does not enforce this. Outputs lag the input by the radius.
`include "gaussian_row_blur_assert.svh"

module gaussian_row_blur #(
	parameter int MAX_RADIUS = grb_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = grb_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [31:0]                        s_tdata,   // red_in, green_in, blue_in, alpha_in
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [31:0]                        m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic                               m_tlast,   // row_end
	// configuration
	input  logic                               cfg_we,
	input  logic [grb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [grb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import grb_pkg::*;

	localparam int N      = 2 * MAX_RADIUS + 1;
	localparam int H      = N / 2;
	localparam int SLOT_W = $clog2(N);
	localparam int KW     = $clog2(MAX_RADIUS + 1);
	localparam int CNT_W  = $clog2(MAX_WIDTH);
	localparam int CMP_W  = ((ROW_WIDTH_W > CNT_W) ? ROW_WIDTH_W : CNT_W) + 2;
	localparam int SUM_W  = PROD_W + $clog2(N);
	localparam int WS_W   = WEIGHT_W + $clog2(N);

	// Configuration registers
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [RADIUS_W-1:0]    radius_q;
	weight_tab_t            weights_q;

	// Control state
	blur_state_t       state_q, state_nx;
	logic [CNT_W-1:0]  col_q;
	logic [KW-1:0]     k_q;
	logic [KW-1:0]     rad_q;
	logic [SLOT_W-1:0] newest_q;
	logic              last_q;

	// Output register
	logic              m_tvalid_q;
	pixel_t            m_tdata_q;
	logic              m_tlast_q;

	// Request decode
	logic              accept;
	logic              calc;
	logic              div_start;
	logic              out_load;
	logic              more;
	logic [KW-1:0]     rad_e;
	logic [CMP_W-1:0]  eff_width;
	logic              row_last;
	logic              past_rad;
	logic              has_out;
	logic [KW-1:0]     k_init;
	logic [SLOT_W-1:0] newest_init;

	// Cell chain and sums
	pixel_t              cell_pix [N];
	prod_vec_t           cell_prod [N];
	logic [WEIGHT_W-1:0] cell_wt [N];
	logic [NUM_CH-1:0][SUM_W-1:0] lo_sum, hi_sum, lo_s2, hi_s2, acc;
	logic [WS_W-1:0]     wlo_sum, whi_sum, wlo_s2, whi_s2;
	logic                div_done;
	pixel_t              div_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= RST_ROW_WIDTH;
			radius_q     <= RST_RADIUS;
			weights_q[0] <= RST_WEIGHT_0;
			weights_q[1] <= RST_WEIGHT_1;
			weights_q[2] <= RST_WEIGHT_2;
			weights_q[3] <= RST_WEIGHT_3;
			weights_q[4] <= RST_WEIGHT_4;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH: row_width_q  <= cfg_data[ROW_WIDTH_W-1:0];
				REG_RADIUS:    radius_q     <= cfg_data[RADIUS_W-1:0];
				REG_WEIGHT_0:  weights_q[0] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_1:  weights_q[1] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_2:  weights_q[2] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_3:  weights_q[3] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_4:  weights_q[4] <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped settings and what the incoming pixel causes
	always_comb begin
		rad_e = (32'(radius_q) > MAX_RADIUS) ? KW'(MAX_RADIUS) : KW'(radius_q);
		if (row_width_q == '0) begin
			eff_width = CMP_W'(1);
		end else if (32'(row_width_q) > MAX_WIDTH) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end else begin
			eff_width = CMP_W'(row_width_q);
		end
		row_last    = (CMP_W'(col_q) + 1'b1) >= eff_width;
		past_rad    = CMP_W'(col_q) >= CMP_W'(rad_e);
		has_out     = row_last || past_rad;
		k_init      = (row_last && !past_rad) ? KW'(col_q) : rad_e;
		newest_init = (32'(col_q) >= N - 1) ? SLOT_W'(N - 1) : SLOT_W'(col_q);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Sequencer
	always_comb begin
		state_nx  = state_q;
		accept    = 1'b0;
		calc      = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		s_tready  = 1'b0;
		more      = last_q && (k_q != '0);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept = 1'b1;
					if (has_out) begin
						state_nx = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				calc     = 1'b1;
				state_nx = ST_SUM;
			end
			ST_SUM: begin
				state_nx = ST_ADD;
			end
			ST_ADD: begin
				div_start = 1'b1;
				state_nx  = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_nx = more ? ST_MUL : ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Row position and per-item context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			k_q      <= '0;
			rad_q    <= '0;
			newest_q <= '0;
			last_q   <= 1'b0;
		end else if (accept) begin
			col_q    <= row_last ? '0 : col_q + 1'b1;
			k_q      <= k_init;
			rad_q    <= rad_e;
			newest_q <= newest_init;
			last_q   <= row_last;
		end else if (out_load && more) begin
			k_q <= k_q - 1'b1;
		end
	end

	// Window cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		pixel_t pix_in;
		if (i == 0) begin : g_head
			assign pix_in = pixel_t'(s_tdata);
		end else begin : g_link
			assign pix_in = cell_pix[i-1];
		end
		grb_cell #(
			.SLOT   (i),
			.SLOT_W (SLOT_W),
			.KW     (KW)
		) u_cell (
			.clk     (clk),
			.shift   (accept),
			.pix_in  (pix_in),
			.pix_out (cell_pix[i]),
			.calc    (calc),
			.lag     (k_q),
			.newest  (newest_q),
			.rad     (rad_q),
			.weights (weights_q),
			.prod    (cell_prod[i]),
			.wt      (cell_wt[i])
		);
	end

	// Half sums over the cells
	always_comb begin
		lo_sum  = '0;
		hi_sum  = '0;
		wlo_sum = '0;
		whi_sum = '0;
		for (int i = 0; i < N; i++) begin
			if (i < H) begin
				for (int c = 0; c < NUM_CH; c++) begin
					lo_sum[c] = lo_sum[c] + SUM_W'(cell_prod[i][c]);
				end
				wlo_sum = wlo_sum + WS_W'(cell_wt[i]);
			end else begin
				for (int c = 0; c < NUM_CH; c++) begin
					hi_sum[c] = hi_sum[c] + SUM_W'(cell_prod[i][c]);
				end
				whi_sum = whi_sum + WS_W'(cell_wt[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_s2  <= lo_sum;
		hi_s2  <= hi_sum;
		wlo_s2 <= wlo_sum;
		whi_s2 <= whi_sum;
	end

	// Final add feeds the divider
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc[c] = lo_s2[c] + hi_s2[c];
		end
	end

	grb_div #(
		.SUM_W (SUM_W),
		.WS_W  (WS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc),
		.divisor  (wlo_s2 + whi_s2),
		.done     (div_done),
		.quotient (div_q)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= div_q;
			m_tlast_q <= last_q && (k_q == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Checks
	`GRB_ASSERT_SAME(a_div_in_div, div_done, state_q == ST_DIV, "divider finished outside its state")
	`GRB_ASSERT_NEXT(a_row_wrap, accept && row_last, col_q == '0, "column count did not wrap at row end")
	`GRB_ASSERT_NEXT(a_no_result_idle, accept && !has_out, state_q == ST_IDLE, "work started for a pixel with no result")
	`GRB_ASSERT_SAME(a_out_free, out_load, !m_tvalid_q || m_tready, "pending result overwritten")

endmodule
